@@ rtl/core/atfr_pkg.sv @@
package atfr_pkg;

  localparam int unsigned AreaSlotsDefault = 16;
  localparam int unsigned PageBytesDefault = 32'h1000;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FAULT  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_STRIP  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERLAP  = 3'd1,
    ST_FULL     = 3'd2,
    ST_PROT     = 3'd3,
    ST_UNMAPPED = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_LINEAR = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_FILE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LINEAR = 2'd1,
    ACT_ZERO   = 2'd2,
    ACT_FILE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } state_e;

  // one table entry as stored in the area memory
  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [1:0]  kind;
    logic [15:0] flags;
    logic [31:0] base_value;
    logic [31:0] file_len;
  } area_t;

  localparam int unsigned AreaW = $bits(area_t);

endpackage

@@ rtl/core/atfr_ram.sv @@
module atfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/area_table_fault_resolver.sv @@
// Every operation goes from input beat to result beat through S_SCAN, S_WRITE and S_RESP
// (one memory read per slot over the single area RAM read port, then resolve).
// One item at a time: in_stall_o holds off a new item until the result beat has been taken.
// Reset: rst_ni clears all slot valid bits and the control state; RAM contents stay unknown.
module area_table_fault_resolver #(
  parameter int unsigned AREA_SLOTS = atfr_pkg::AreaSlotsDefault,
  parameter int unsigned PAGE_BYTES = atfr_pkg::PageBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] start_addr_i,
  input  logic [31:0] end_addr_i,
  input  logic [1:0]  area_kind_i,
  input  logic [15:0] area_flags_i,
  input  logic [31:0] base_value_i,
  input  logic [31:0] file_len_i,
  input  logic [3:0]  slot_index_i,
  input  logic        protection_error_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_found_o,
  output logic [1:0]  action_o,
  output logic [31:0] page_addr_o,
  output logic [31:0] target_value_o,
  output logic [12:0] rd_bytes_o,
  output logic [15:0] found_flags_o,
  output logic [4:0]  removed_count_o
);

  import atfr_pkg::*;

  localparam int unsigned IdxW = $clog2(AREA_SLOTS);
  localparam int unsigned CntW = $clog2(AREA_SLOTS + 1);
  localparam logic [31:0] PageMask = ~(PAGE_BYTES - 1);

  state_e state_q, state_d;

  logic [AREA_SLOTS-1:0] valid_q, valid_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0] chk_cnt_q, chk_cnt_d;
  logic            chk_q, chk_d;

  logic [2:0]  op_q;
  logic [31:0] sa_q, ea_q, base_q, fsz_q;
  logic [1:0]  kind_q;
  logic [15:0] flg_q;
  logic [3:0]  idx_q;
  logic        prot_q;

  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  area_t           hit_area_q, hit_area_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            ovl_q, ovl_d;
  logic [4:0]      strip_n_q, strip_n_d;

  logic            out_v_q;
  logic [2:0]      st_q;
  logic [3:0]      slot_q;
  logic [1:0]      act_q;
  logic [31:0]     page_q, tgt_q;
  logic [12:0]     rc_q;
  logic [15:0]     ff_q;
  logic [4:0]      rm_q;

  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  area_t           ram_wdata, ram_rdata;
  logic            accept;
  logic [IdxW-1:0] chk_idx;
  logic            rm_ok;

  atfr_ram #(
    .Width(AreaW),
    .Depth(AREA_SLOTS)
  ) u_area_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_v_q;
  assign ram_raddr  = rd_cnt_q[IdxW-1:0];
  assign chk_idx    = chk_cnt_q[IdxW-1:0];
  assign ram_we     = (state_q == S_WRITE) && (op_q == OP_INSERT) && !ovl_q && free_q;
  assign ram_wdata  = '{start_addr: sa_q, end_addr: ea_q, kind: kind_q, flags: flg_q,
                        base_value: base_q, file_len: fsz_q};
  assign rm_ok      = ({28'd0, idx_q} < 32'(AREA_SLOTS)) && valid_q[IdxW'(idx_q)];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (chk_q && chk_cnt_q == CntW'(AREA_SLOTS - 1)) state_d = S_WRITE;
      S_WRITE: state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    chk_cnt_d  = chk_cnt_q;
    chk_d      = 1'b0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_area_d = hit_area_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    ovl_d      = ovl_q;
    strip_n_d  = strip_n_q;
    valid_d    = valid_q;
    unique case (state_q)
      S_IDLE: begin
        rd_cnt_d  = '0;
        chk_cnt_d = '0;
        hit_d     = 1'b0;
        free_d    = 1'b0;
        ovl_d     = 1'b0;
        strip_n_d = '0;
        hit_idx_d = '0;
        free_idx_d = '0;
      end
      S_SCAN: begin
        if (rd_cnt_q != CntW'(AREA_SLOTS)) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
          chk_d    = 1'b1;
        end
        if (chk_q) begin
          chk_cnt_d = chk_cnt_q + 1'b1;
          if (valid_q[chk_idx]) begin
            if (!hit_q && sa_q >= ram_rdata.start_addr && sa_q < ram_rdata.end_addr) begin
              hit_d      = 1'b1;
              hit_idx_d  = chk_idx;
              hit_area_d = ram_rdata;
            end
            if (sa_q < ram_rdata.end_addr && ea_q > ram_rdata.start_addr) begin
              ovl_d = 1'b1;
            end
            if (op_q == OP_STRIP && (ram_rdata.flags & flg_q) == 16'h0) begin
              valid_d[chk_idx] = 1'b0;
              strip_n_d        = strip_n_q + 1'b1;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx;
          end
        end
      end
      S_WRITE: begin
        if (ram_we) valid_d[free_idx_q] = 1'b1;
        // hold the remove outcome for the result beat
        if (op_q == OP_REMOVE) begin
          hit_d = rm_ok;
          if (rm_ok) valid_d[IdxW'(idx_q)] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result assembly from scan outcome
  logic [2:0]  r_st;
  logic [3:0]  r_slot;
  logic [1:0]  r_act;
  logic [31:0] r_page, r_tgt, r_off;
  logic [12:0] r_rc;
  logic [15:0] r_ff;
  logic [4:0]  r_rm;
  logic signed [34:0] r_rem;

  always_comb begin
    r_st   = ST_OK;
    r_slot = '0;
    r_act  = ACT_NONE;
    r_page = '0;
    r_tgt  = '0;
    r_rc   = '0;
    r_ff   = '0;
    r_rm   = '0;
    r_off  = (sa_q & PageMask) - hit_area_q.start_addr;
    r_rem  = $signed({3'b000, hit_area_q.file_len}) + $signed({3'b000, hit_area_q.start_addr})
           - $signed({3'b000, sa_q & PageMask});
    case (op_q)
      OP_INSERT: begin
        if (ovl_q) r_st = ST_OVERLAP;
        else if (!free_q) r_st = ST_FULL;
        else r_slot = 4'(free_idx_q);
      end
      OP_REMOVE: begin
        if (hit_q) r_slot = idx_q;
        else r_st = ST_EMPTY;
      end
      OP_FAULT: begin
        r_page = sa_q & PageMask;
        if (prot_q) r_st = ST_PROT;
        else if (!hit_q) r_st = ST_UNMAPPED;
        else begin
          r_slot = 4'(hit_idx_q);
          r_ff   = hit_area_q.flags;
          case (hit_area_q.kind)
            KIND_LINEAR: begin
              r_act = ACT_LINEAR;
              r_tgt = hit_area_q.base_value + r_off;
            end
            KIND_ALLOC: r_act = ACT_ZERO;
            KIND_FILE: begin
              r_act = ACT_FILE;
              r_tgt = hit_area_q.base_value + r_off;
              if (r_rem < 0) r_rc = '0;
              else if (r_rem > $signed({3'b000, 32'(PAGE_BYTES)})) r_rc = 13'(PAGE_BYTES);
              else r_rc = r_rem[12:0];
            end
            default: r_act = ACT_NONE;
          endcase
        end
      end
      OP_LOOKUP: begin
        if (!hit_q) r_st = ST_UNMAPPED;
        else begin
          r_slot = 4'(hit_idx_q);
          r_ff   = hit_area_q.flags;
        end
      end
      OP_STRIP: r_rm = strip_n_q;
      default: r_st = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      rd_cnt_q  <= '0;
      chk_cnt_q <= '0;
      chk_q     <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      rd_cnt_q  <= rd_cnt_d;
      chk_cnt_q <= chk_cnt_d;
      chk_q     <= chk_d;
      if (state_q == S_RESP) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      sa_q   <= start_addr_i;
      ea_q   <= end_addr_i;
      kind_q <= area_kind_i;
      flg_q  <= area_flags_i;
      base_q <= base_value_i;
      fsz_q  <= file_len_i;
      idx_q  <= slot_index_i;
      prot_q <= protection_error_i;
    end
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_area_q <= hit_area_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    ovl_q      <= ovl_d;
    strip_n_q  <= strip_n_d;
    if (state_q == S_RESP) begin
      st_q   <= r_st;
      slot_q <= r_slot;
      act_q  <= r_act;
      page_q <= r_page;
      tgt_q  <= r_tgt;
      rc_q   <= r_rc;
      ff_q   <= r_ff;
      rm_q   <= r_rm;
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = st_q;
  assign slot_found_o    = slot_q;
  assign action_o        = act_q;
  assign page_addr_o     = page_q;
  assign target_value_o  = tgt_q;
  assign rd_bytes_o      = rc_q;
  assign found_flags_o   = ff_q;
  assign removed_count_o = rm_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !accept) else $error("accept while busy");
  a_write_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[free_idx_q]) else $error("insert over valid slot");
  a_result_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> out_v_q) else $error("result lost");
`endif

endmodule

@@ tb/area_table_fault_resolver_test.sv @@
`timescale 1ns / 1ps

module area_table_fault_resolver_test;
  import atfr_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] sa;
    logic [31:0] ea;
    logic [1:0]  kind;
    logic [15:0] flags;
    logic [31:0] base;
    logic [31:0] fsize;
    logic [3:0]  idx;
    logic        prot;
    bit          drain;
  } area_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [1:0]  action;
    logic [31:0] page;
    logic [31:0] target;
    logic [12:0] rcount;
    logic [15:0] flags;
    logic [4:0]  removed;
  } area_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [31:0] start_addr_i;
  logic [31:0] end_addr_i;
  logic [1:0]  area_kind_i;
  logic [15:0] area_flags_i;
  logic [31:0] base_value_i;
  logic [31:0] file_len_i;
  logic [3:0]  slot_index_i;
  logic        protection_error_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [3:0]  slot_found_o;
  logic [1:0]  action_o;
  logic [31:0] page_addr_o;
  logic [31:0] target_value_o;
  logic [12:0] rd_bytes_o;
  logic [15:0] found_flags_o;
  logic [4:0]  removed_count_o;

  area_table_fault_resolver dut (.*);

  area_req_t  pending_reqs[$];
  area_resp_t expected_resps[$];
  bit          tbl_valid[16];
  logic [31:0] tbl_start[16];
  logic [31:0] tbl_end[16];
  logic [1:0]  tbl_kind[16];
  logic [15:0] tbl_flags[16];
  logic [31:0] tbl_base[16];
  logic [31:0] tbl_size[16];
  int  errors = 0;
  bit  stim_done = 0;
  int  hold_off = 0;
  bit  long_hold = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  function automatic int covering(logic [31:0] a);
    for (int i = 0; i < 16; i++)
      if (tbl_valid[i] && a >= tbl_start[i] && a < tbl_end[i]) return i;
    return -1;
  endfunction

  function automatic area_resp_t resolve(area_req_t q);
    area_resp_t r;
    int s;
    bit hit;
    longint rem;
    logic [31:0] off;
    r = '{default: '0};
    case (q.op)
      OP_INSERT: begin
        hit = 0;
        for (int i = 0; i < 16; i++)
          if (tbl_valid[i] && q.sa < tbl_end[i] && q.ea > tbl_start[i]) hit = 1;
        if (hit) begin
          r.status = ST_OVERLAP;
        end else begin
          s = -1;
          for (int i = 15; i >= 0; i--) if (!tbl_valid[i]) s = i;
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_valid[s] = 1;
            tbl_start[s] = q.sa;
            tbl_end[s] = q.ea;
            tbl_kind[s] = q.kind;
            tbl_flags[s] = q.flags;
            tbl_base[s] = q.base;
            tbl_size[s] = q.fsize;
            r.status = ST_OK;
            r.slot = 4'(s);
          end
        end
      end
      OP_REMOVE: begin
        if (tbl_valid[q.idx]) begin
          tbl_valid[q.idx] = 0;
          r.status = ST_OK;
          r.slot = q.idx;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_FAULT: begin
        r.page = q.sa & ~32'hFFF;
        if (q.prot) begin
          r.status = ST_PROT;
        end else begin
          s = covering(q.sa);
          if (s < 0) begin
            r.status = ST_UNMAPPED;
          end else begin
            off = r.page - tbl_start[s];
            r.status = ST_OK;
            r.slot = 4'(s);
            r.flags = tbl_flags[s];
            case (tbl_kind[s])
              KIND_LINEAR: begin
                r.action = ACT_LINEAR;
                r.target = tbl_base[s] + off;
              end
              KIND_ALLOC: r.action = ACT_ZERO;
              KIND_FILE: begin
                rem = longint'(tbl_size[s]) + longint'(tbl_start[s]) - longint'(r.page);
                if (rem < 0) rem = 0;
                if (rem > 4096) rem = 4096;
                r.action = ACT_FILE;
                r.target = tbl_base[s] + off;
                r.rcount = rem[12:0];
              end
              default: r.action = ACT_NONE;
            endcase
          end
        end
      end
      OP_LOOKUP: begin
        s = covering(q.sa);
        if (s < 0) begin
          r.status = ST_UNMAPPED;
        end else begin
          r.status = ST_OK;
          r.slot = 4'(s);
          r.flags = tbl_flags[s];
        end
      end
      OP_STRIP: begin
        for (int i = 0; i < 16; i++)
          if (tbl_valid[i] && (tbl_flags[i] & q.flags) == 16'h0) begin
            tbl_valid[i] = 0;
            r.removed++;
          end
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic area_req_t mk(logic [2:0] op, logic [31:0] sa, logic [31:0] ea,
                                   logic [1:0] kind, logic [15:0] flags,
                                   logic [31:0] base, logic [31:0] fsize,
                                   logic [3:0] idx, logic prot);
    area_req_t q;
    q.op = op;
    q.sa = sa;
    q.ea = ea;
    q.kind = kind;
    q.flags = flags;
    q.base = base;
    q.fsize = fsize;
    q.idx = idx;
    q.prot = prot;
    q.drain = 0;
    return q;
  endfunction

  function automatic void add_req(area_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic area_req_t rand_req();
    area_req_t q;
    int pick;
    logic [31:0] region;
    q = mk(3'($urandom_range(0, 7)), $urandom, $urandom, 2'($urandom_range(0, 3)),
           16'($urandom), $urandom, $urandom, 4'($urandom), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    region = {4'($urandom_range(0, 15)), 28'h0};
    if (pick < 35) begin
      q.op = OP_INSERT;
      q.sa = region + ($urandom_range(0, 255) << 12) + $urandom_range(0, 3) * $urandom_range(0, 4095);
      q.ea = q.sa + $urandom_range(1, 8) * 32'h1000 + $urandom_range(0, 1) * $urandom_range(0, 4095);
      if ($urandom_range(0, 19) == 0) q.ea = q.sa - $urandom_range(0, 5);
      q.kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      q.fsize = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000);
    end else if (pick < 70) begin
      q.op = $urandom_range(0, 3) == 0 ? OP_LOOKUP : OP_FAULT;
      q.prot = $urandom_range(0, 7) == 0;
      if ($urandom_range(0, 4) != 0) begin
        q.sa = region + ($urandom_range(0, 263) << 12) + $urandom_range(0, 4095);
      end
    end else if (pick < 85) begin
      q.op = OP_REMOVE;
    end else if (pick < 90) begin
      q.op = OP_STRIP;
    end
    return q;
  endfunction

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    area_req_t q;
    rst_ni = 0;
    for (int i = 0; i < 16; i++) tbl_valid[i] = 0;
    add_req(mk(OP_FAULT, 32'h0000_5123, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_REMOVE, '0, '0, '0, '0, '0, '0, 4'd15, 1'b0));
    add_req(mk(OP_INSERT, 32'h0000_1000, 32'h0000_5000, KIND_LINEAR, 16'hFFFF,
               32'hFFFF_F000, '0, '0, 1'b0));
    add_req(mk(OP_INSERT, 32'h0000_4000, 32'h0000_6000, KIND_ALLOC, 16'h0001, '0, '0, '0,
               1'b0));
    add_req(mk(OP_INSERT, 32'h0001_0800, 32'hFFFF_FFFF, KIND_FILE, 16'h0002,
               32'h8000_0000, 32'h0000_1900, '0, 1'b0));
    add_req(mk(OP_INSERT, 32'h0000_9000, 32'h0000_9000, KIND_ALLOC, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_INSERT, 32'h0000_7000, 32'h0000_6000, 2'd3, 16'h8000, '0, '0, '0, 1'b0));
    add_req(mk(OP_INSERT, 32'h0000_0000, 32'h0000_1000, 2'd3, 16'h4000, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0000_0FFF, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0000_4FFF, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0000_5001, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0001_0900, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0001_1000, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'h0001_3000, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_FAULT, 32'hFFFF_FFFE, '0, '0, '0, '0, '0, '0, 1'b1));
    add_req(mk(OP_FAULT, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_LOOKUP, 32'h0000_2000, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_LOOKUP, 32'h0000_9000, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 16'hFFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
    add_req(mk(3'd5, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    add_req(mk(OP_STRIP, '0, '0, '0, 16'h0001, '0, '0, '0, 1'b0));
    add_req(mk(OP_REMOVE, '0, '0, '0, '0, '0, '0, 4'd0, 1'b0));
    add_req(mk(OP_STRIP, '0, '0, '0, 16'h0000, '0, '0, '0, 1'b0));
    for (int i = 0; i < 17; i++)
      add_req(mk(OP_INSERT, 32'(i) << 12, (32'(i) << 12) + 32'h1000, KIND_ALLOC,
                 16'hFFFF, '0, '0, '0, 1'b0));
    q = mk(OP_STRIP, '0, '0, '0, 16'hFFFF, '0, '0, '0, 1'b0);
    q.drain = 1;
    add_req(q);
    for (int i = 0; i < 600; i++) begin
      q = rand_req();
      q.drain = (i == 300);
      add_req(q);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= '0;
      start_addr_i <= '0;
      end_addr_i <= '0;
      area_kind_i <= '0;
      area_flags_i <= '0;
      base_value_i <= '0;
      file_len_i <= '0;
      slot_index_i <= '0;
      protection_error_i <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_resps.insert(expected_resps.size(), resolve(pending_reqs.pop_front()));
        in_valid_i <= 1'b0;
        in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end else if (!in_valid_i && pending_reqs.size() > 0) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (!pending_reqs[0].drain || expected_resps.size() == 0) begin
          in_valid_i <= 1'b1;
          operation_i <= pending_reqs[0].op;
          start_addr_i <= pending_reqs[0].sa;
          end_addr_i <= pending_reqs[0].ea;
          area_kind_i <= pending_reqs[0].kind;
          area_flags_i <= pending_reqs[0].flags;
          base_value_i <= pending_reqs[0].base;
          file_len_i <= pending_reqs[0].fsize;
          slot_index_i <= pending_reqs[0].idx;
          protection_error_i <= pending_reqs[0].prot;
        end
      end
      if (!in_valid_i && pending_reqs.size() == 0) stim_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    area_resp_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
      hold_off <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_resps.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_resps.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (slot_found_o !== e.slot) begin
            $error("slot_found exp %0d got %0d", e.slot, slot_found_o); errors++;
          end
          if (action_o !== e.action) begin
            $error("action exp %0d got %0d", e.action, action_o); errors++;
          end
          if (page_addr_o !== e.page) begin
            $error("page_addr exp %h got %h", e.page, page_addr_o); errors++;
          end
          if (target_value_o !== e.target) begin
            $error("target_value exp %h got %h", e.target, target_value_o); errors++;
          end
          if (rd_bytes_o !== e.rcount) begin
            $error("rd_bytes exp %0d got %0d", e.rcount, rd_bytes_o); errors++;
          end
          if (found_flags_o !== e.flags) begin
            $error("found_flags exp %h got %h", e.flags, found_flags_o); errors++;
          end
          if (removed_count_o !== e.removed) begin
            $error("removed_count exp %0d got %0d", e.removed, removed_count_o); errors++;
          end
        end
        out_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (!long_hold && pending_reqs.size() < 400 && expected_resps.size() > 0) begin
        long_hold <= 1'b1;
        hold_off <= 200;
        out_stall_i <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_stall_i <= 1'($urandom_range(0, 1));
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    wait (stim_done && expected_resps.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS area_table_fault_resolver");
    end else begin
      $display("FAIL area_table_fault_resolver");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL area_table_fault_resolver");
    $finish;
  end

endmodule
